@@ sv/mroe_pkg.sv @@
// Shared types and constants for the matrix row operation engine.
// Holds the item and result payloads, operation and register codes, and FSM states.
// No dependencies.
package mroe_pkg;

  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;

  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_DATA_W-1:0] NUM_EQ_RST  = 5'd16;
  localparam logic [CFG_DATA_W-1:0] NUM_UNK_RST = 5'd16;

  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0,
    FUNC_READ  = 3'd1,
    FUNC_SWAP  = 3'd2,
    FUNC_SCALE = 3'd3,
    FUNC_SUB   = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_EQ  = 2'd0,
    CFG_NUM_UNK = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [2:0]               func;
    logic [3:0]               row_a;
    logic [3:0]               row_b;
    logic [4:0]               column;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     status;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic  valid;
    func_e func;
  } stage_t;

endpackage

@@ sv/mroe_store.sv @@
// Matrix element memory: one write port, two registered read ports on a shared column.
// Depth is MAX_ROWS rows of MAX_COLS coefficients plus one right-hand side word.
// Depends on mroe_pkg.
module mroe_store #(
  parameter int MAX_ROWS = mroe_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mroe_pkg::DEF_MAX_COLS
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [$clog2(MAX_ROWS)-1:0]           wr_row_i,
  input  logic [$clog2(MAX_COLS+1)-1:0]         wr_col_i,
  input  logic signed [mroe_pkg::DATA_W-1:0]    wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [$clog2(MAX_ROWS)-1:0]           rd_row_a_i,
  input  logic [$clog2(MAX_ROWS)-1:0]           rd_row_b_i,
  input  logic [$clog2(MAX_COLS+1)-1:0]         rd_col_i,
  output logic signed [mroe_pkg::DATA_W-1:0]    rd_data_a_o,
  output logic signed [mroe_pkg::DATA_W-1:0]    rd_data_b_o
);
  import mroe_pkg::*;

  logic signed [DATA_W-1:0] mem [MAX_ROWS][MAX_COLS+1];
  logic signed [DATA_W-1:0] rd_a_q;
  logic signed [DATA_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i][wr_col_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem[rd_row_a_i][rd_col_i];
      rd_b_q <= mem[rd_row_b_i][rd_col_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

@@ sv/mroe_alu.sv @@
// Read-modify-write datapath: product register, floor shift, subtract, clamp and write back.
// Swap writes the two rows on consecutive cycles; read captures the element.
// Depends on mroe_pkg.
module mroe_alu #(
  parameter int MAX_ROWS = mroe_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mroe_pkg::DEF_MAX_COLS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mroe_pkg::stage_t                      iss_i,
  input  logic [$clog2(MAX_COLS+1)-1:0]         iss_col_i,
  input  logic [$clog2(MAX_ROWS)-1:0]           row_a_i,
  input  logic [$clog2(MAX_ROWS)-1:0]           row_b_i,
  input  logic signed [mroe_pkg::DATA_W-1:0]    value_i,
  input  logic signed [mroe_pkg::DATA_W-1:0]    rd_data_a_i,
  input  logic signed [mroe_pkg::DATA_W-1:0]    rd_data_b_i,
  output logic                                  wr_en_o,
  output logic [$clog2(MAX_ROWS)-1:0]           wr_row_o,
  output logic [$clog2(MAX_COLS+1)-1:0]         wr_col_o,
  output logic signed [mroe_pkg::DATA_W-1:0]    wr_data_o,
  output logic                                  sat_o,
  output logic                                  idle_o,
  output logic signed [mroe_pkg::DATA_W-1:0]    read_data_o
);
  import mroe_pkg::*;

  localparam int CW     = $clog2(MAX_COLS+1);
  localparam int PROD_W = 2 * DATA_W;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  stage_t                   s1_q, s2_q;
  logic [CW-1:0]            s1_col_q, s2_col_q, s3_col_q;
  logic                     s3_vld_q;
  logic signed [DATA_W-1:0] s3_data_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [DATA_W-1:0] a_q, b_q, rd_q;
  logic signed [DATA_W-1:0] src;
  logic signed [PROD_W-1:0] shifted, mod_val;
  logic                     ovf;
  logic signed [DATA_W-1:0] clamped;

  assign src    = (s1_q.func == FUNC_SUB) ? rd_data_b_i : rd_data_a_i;
  assign prod_d = src * value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= '0;
      s2_q     <= '0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_q     <= iss_i;
      s2_q     <= s1_q;
      s3_vld_q <= s2_q.valid && (s2_q.func == FUNC_SWAP);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_col_q  <= iss_col_i;
    s2_col_q  <= s1_col_q;
    s3_col_q  <= s2_col_q;
    prod_q    <= prod_d;
    a_q       <= rd_data_a_i;
    b_q       <= rd_data_b_i;
    s3_data_q <= a_q;
    if (s1_q.valid && (s1_q.func == FUNC_READ)) begin
      rd_q <= rd_data_a_i;
    end
  end

  always_comb begin
    shifted = prod_q >>> 16;
    if (s2_q.func == FUNC_SUB) begin
      mod_val = {{DATA_W{a_q[DATA_W-1]}}, a_q} - shifted;
    end else begin
      mod_val = shifted;
    end
    ovf     = !((&mod_val[PROD_W-1:DATA_W-1]) || !(|mod_val[PROD_W-1:DATA_W-1]));
    clamped = ovf ? (mod_val[PROD_W-1] ? Q_MIN : Q_MAX) : mod_val[DATA_W-1:0];
  end

  always_comb begin
    wr_en_o   = 1'b0;
    wr_row_o  = row_a_i;
    wr_col_o  = s2_col_q;
    wr_data_o = clamped;
    sat_o     = 1'b0;
    if (s3_vld_q) begin
      wr_en_o   = 1'b1;
      wr_row_o  = row_b_i;
      wr_col_o  = s3_col_q;
      wr_data_o = s3_data_q;
    end else if (s2_q.valid) begin
      case (s2_q.func) inside
        FUNC_WRITE: begin
          wr_en_o   = 1'b1;
          wr_data_o = value_i;
        end
        FUNC_SCALE, FUNC_SUB: begin
          wr_en_o = 1'b1;
          sat_o   = ovf;
        end
        FUNC_SWAP: begin
          wr_en_o   = 1'b1;
          wr_data_o = b_q;
        end
        default: begin
          wr_en_o = 1'b0;
        end
      endcase
    end
  end

  assign idle_o      = !s1_q.valid && !s2_q.valid && !s3_vld_q;
  assign read_data_o = rd_q;

endmodule

@@ sv/mroe_ctrl.sv @@
// Sequencer: configuration registers, range checks, column issue counter and result register.
// Drives the memory read ports and the datapath stage control.
// Depends on mroe_pkg.
module mroe_ctrl #(
  parameter int MAX_ROWS = mroe_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mroe_pkg::DEF_MAX_COLS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  mroe_pkg::item_t                       item_i,
  output logic                                  done_o,
  output mroe_pkg::result_t                     result_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mroe_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mroe_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output mroe_pkg::stage_t                      iss_o,
  output logic [$clog2(MAX_COLS+1)-1:0]         iss_col_o,
  output logic [$clog2(MAX_ROWS)-1:0]           row_a_o,
  output logic [$clog2(MAX_ROWS)-1:0]           row_b_o,
  output logic signed [mroe_pkg::DATA_W-1:0]    value_o,
  input  logic                                  alu_idle_i,
  input  logic                                  alu_sat_i,
  input  logic signed [mroe_pkg::DATA_W-1:0]    read_data_i
);
  import mroe_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS+1);

  state_e                   state_q, state_d;
  logic [CFG_DATA_W-1:0]    num_eq_q, num_unk_q;
  logic [CW-1:0]            k_q, k_d;
  logic                     ph_q, ph_d;
  logic                     sat_q, sat_d;
  logic                     done_q, done_d;
  result_t                  result_q, result_d;
  func_e                    func_q;
  logic [RW-1:0]            ra_q, rb_q;
  logic [CW-1:0]            col_q, nc_q;
  logic signed [DATA_W-1:0] value_q;

  logic                     accept;
  logic                     a_ok, b_ok, c_ok, dec_err;
  logic [CW-1:0]            nc_eff;
  stage_t                   iss;
  logic [CW-1:0]            iss_col;
  logic                     last;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    nc_eff = (int'(num_unk_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(num_unk_q);
    a_ok   = (int'(item_i.row_a) < int'(num_eq_q)) && (int'(item_i.row_a) < MAX_ROWS);
    b_ok   = (int'(item_i.row_b) < int'(num_eq_q)) && (int'(item_i.row_b) < MAX_ROWS);
    c_ok   = (int'(item_i.column) < int'(nc_eff)) || (int'(item_i.column) == MAX_COLS);
    unique case (item_i.func) inside
      FUNC_WRITE, FUNC_READ: dec_err = !a_ok || !c_ok;
      FUNC_SWAP, FUNC_SUB:   dec_err = !a_ok || !b_ok;
      FUNC_SCALE:            dec_err = !a_ok;
      default:               dec_err = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_eq_q  <= NUM_EQ_RST;
      num_unk_q <= NUM_UNK_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUM_EQ:  num_eq_q  <= cfg_data_i;
        CFG_NUM_UNK: num_unk_q <= cfg_data_i;
        default:     num_eq_q  <= num_eq_q;
      endcase
    end
  end

  always_comb begin
    iss      = '0;
    iss.func = func_q;
    iss_col  = col_q;
    last     = 1'b0;
    if (state_q == ST_ISSUE) begin
      unique case (func_q) inside
        FUNC_SWAP: begin
          iss.valid = !ph_q;
          iss_col   = k_q;
          last      = (k_q == CW'(MAX_COLS));
        end
        FUNC_SCALE, FUNC_SUB: begin
          iss.valid = 1'b1;
          last      = (k_q == nc_q);
          iss_col   = last ? CW'(MAX_COLS) : k_q;
        end
        default: begin
          iss.valid = 1'b1;
          last      = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && !dec_err) state_d = ST_ISSUE;
      ST_ISSUE: if (iss.valid && last)  state_d = ST_DRAIN;
      ST_DRAIN: if (alu_idle_i)         state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    k_d   = k_q;
    ph_d  = ph_q;
    sat_d = sat_q | alu_sat_i;
    if (accept) begin
      k_d   = '0;
      ph_d  = 1'b0;
      sat_d = 1'b0;
    end else if (state_q == ST_ISSUE) begin
      ph_d = !ph_q;
      if (iss.valid) begin
        k_d = k_q + CW'(1);
      end
    end
    done_d              = (accept && dec_err) || ((state_q == ST_DRAIN) && alu_idle_i);
    result_d.status     = accept && dec_err;
    result_d.read_value = ((state_q == ST_DRAIN) && (func_q == FUNC_READ)) ? read_data_i : '0;
    result_d.saturated  = (state_q == ST_DRAIN) && sat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      ph_q    <= 1'b0;
      sat_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ph_q    <= ph_d;
      sat_q   <= sat_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      result_q <= result_d;
    end
    if (accept && !dec_err) begin
      func_q  <= func_e'(item_i.func);
      ra_q    <= RW'(item_i.row_a);
      rb_q    <= RW'(item_i.row_b);
      col_q   <= CW'(item_i.column);
      nc_q    <= nc_eff;
      value_q <= item_i.value;
    end
  end

  assign done_o    = done_q;
  assign result_o  = result_q;
  assign iss_o     = iss;
  assign iss_col_o = iss_col;
  assign row_a_o   = ra_q;
  assign row_b_o   = rb_q;
  assign value_o   = value_q;

endmodule

@@ sv/matrix_row_operation_engine_core.sv @@
// Top level of the matrix row operation engine.
// Instantiates mroe_ctrl, mroe_store and mroe_alu; depends on mroe_pkg.
//
// Holds a Q16.16 augmented matrix in a single memory and runs one row operation per item.
// One item at a time: start is taken while busy is low, and the result is shown on result_o
// for exactly one cycle with done_o high; the receiver cannot stall, so take it then.
// A rejected item (row or column out of range, unknown func) reports in the next cycle.
// Otherwise read and write touch one element; scale and subtract issue one column a cycle
// over the first min(num_unknowns, MAX_COLS) columns and then the right-hand side; swap
// covers every column with two writes per element through the single write port. The matrix
// is not cleared at reset; write each element before reading it. Configuration is always
// ready and is to be written only while busy is low and no result is pending.
module matrix_row_operation_engine_core #(
  parameter int MAX_ROWS = mroe_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mroe_pkg::DEF_MAX_COLS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  mroe_pkg::item_t                  item_i,
  output logic                             done_o,
  output mroe_pkg::result_t                result_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mroe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mroe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mroe_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS+1);

  stage_t                   iss;
  logic [CW-1:0]            iss_col;
  logic [RW-1:0]            row_a, row_b;
  logic signed [DATA_W-1:0] value;
  logic                     alu_idle, alu_sat;
  logic signed [DATA_W-1:0] read_data;
  logic                     wr_en;
  logic [RW-1:0]            wr_row;
  logic [CW-1:0]            wr_col;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] rd_data_a, rd_data_b;

  mroe_ctrl #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .iss_o       (iss),
    .iss_col_o   (iss_col),
    .row_a_o     (row_a),
    .row_b_o     (row_b),
    .value_o     (value),
    .alu_idle_i  (alu_idle),
    .alu_sat_i   (alu_sat),
    .read_data_i (read_data)
  );

  mroe_store #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_row_i    (wr_row),
    .wr_col_i    (wr_col),
    .wr_data_i   (wr_data),
    .rd_en_i     (iss.valid),
    .rd_row_a_i  (row_a),
    .rd_row_b_i  (row_b),
    .rd_col_i    (iss_col),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  mroe_alu #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_alu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_i       (iss),
    .iss_col_i   (iss_col),
    .row_a_i     (row_a),
    .row_b_i     (row_b),
    .value_i     (value),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .wr_en_o     (wr_en),
    .wr_row_o    (wr_row),
    .wr_col_o    (wr_col),
    .wr_data_o   (wr_data),
    .sat_o       (alu_sat),
    .idle_o      (alu_idle),
    .read_data_o (read_data)
  );

endmodule
